>>> sv/bpa_pkg.sv
// shared types, codes and constants of the bitmap page allocator
package bpa_pkg;

  localparam int MAX_PAGES_DEF = 4096;
  localparam int DIVW          = 12;   // width of a dividend fed to the remainder unit
  localparam int CNTW          = 13;   // width of page_count and region_pages
  localparam int PGW           = 12;   // width of a page index field

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_RESERVE = 2'd2,
    ACT_COLOR   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_INVAL   = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    CFG_REGION = 2'd0,
    CFG_SEARCH = 2'd1,
    CFG_COLORS = 2'd2,
    CFG_FIRST  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    RES_OK    = 2'd0,
    RES_FAIL  = 2'd1,
    RES_INVAL = 2'd2,
    RES_HIT   = 2'd3
  } res_t;

  typedef enum logic [1:0] {
    SEL_SEARCH = 2'd0,
    SEL_COLOR  = 2'd1,
    SEL_FIRST  = 2'd2
  } rem_sel_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_REM_S,
    S_ASCAN,
    S_MARK,
    S_SET,
    S_REM_C,
    S_REM_F,
    S_CSCAN,
    S_HIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     clr;
    logic     rem_go;
    rem_sel_t rem_sel;
    logic     alloc_init;
    logic     scan_a;
    logic     col_save;
    logic     col_init;
    logic     scan_c;
    logic     set_init;
    logic     set_src_found;
    logic     set_val;
    logic     set_step;
    logic     res_wr;
    res_t     res;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    act_t act;
    logic n_zero;
    logic start_out;
    logic cnt_zero;
    logic rem_done;
    logic hit;
    logic fail;
    logic set_last;
  } sts_t;

endpackage

>>> sv/bpa_rem.sv
// restoring remainder unit, one dividend bit per cycle
module bpa_rem #(
  parameter int DW = 14
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [bpa_pkg::DIVW-1:0]  dividend,
  input  logic [DW-1:0]             divisor,
  output logic                      done,
  output logic [DW-1:0]             rem
);

  localparam int SW = $clog2(bpa_pkg::DIVW);

  logic                     run_r;
  logic                     done_r;
  logic [SW-1:0]            step_r;
  logic [DW-1:0]            r_r;
  logic [DW-1:0]            d_r;
  logic [bpa_pkg::DIVW-1:0] dv_r;
  logic [DW:0]              t_sh;
  logic [DW:0]              r_nxt;

  always_comb begin
    t_sh  = {r_r, dv_r[bpa_pkg::DIVW-1]};
    r_nxt = (t_sh >= {1'b0, d_r}) ? t_sh - {1'b0, d_r} : t_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == SW'(bpa_pkg::DIVW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // partial remainder stays below the divisor, so the top bit is always zero
  always_ff @(posedge clk) begin
    if (go) begin
      r_r  <= '0;
      d_r  <= divisor;
      dv_r <= dividend;
    end else if (run_r) begin
      r_r  <= r_nxt[DW-1:0];
      dv_r <= {dv_r[bpa_pkg::DIVW-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign rem  = r_r;

endmodule

>>> sv/bpa_ctrl.sv
// controller state machine: sequences clear, search, marking and result
module bpa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           out_valid,
  input  bpa_pkg::sts_t  sts,
  output bpa_pkg::cmd_t  cmd
);

  bpa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpa_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      bpa_pkg::S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = bpa_pkg::S_DISPATCH;
        end
      end
      bpa_pkg::S_DISPATCH: begin
        unique case (sts.act)
          bpa_pkg::ACT_ALLOC: begin
            if (sts.n_zero) begin
              cmd.res_wr = 1'b1;
              cmd.res    = bpa_pkg::RES_FAIL;
              state_nxt  = bpa_pkg::S_DONE;
            end else begin
              cmd.rem_go  = 1'b1;
              cmd.rem_sel = bpa_pkg::SEL_SEARCH;
              state_nxt   = bpa_pkg::S_REM_S;
            end
          end
          bpa_pkg::ACT_FREE: begin
            if (sts.start_out) begin
              cmd.res_wr = 1'b1;
              cmd.res    = bpa_pkg::RES_INVAL;
              state_nxt  = bpa_pkg::S_DONE;
            end else if (sts.cnt_zero) begin
              cmd.res_wr = 1'b1;
              cmd.res    = bpa_pkg::RES_OK;
              state_nxt  = bpa_pkg::S_DONE;
            end else begin
              cmd.set_init = 1'b1;
              cmd.set_val  = 1'b0;
              state_nxt    = bpa_pkg::S_SET;
            end
          end
          bpa_pkg::ACT_RESERVE: begin
            if (sts.start_out || sts.cnt_zero) begin
              cmd.res_wr = 1'b1;
              cmd.res    = bpa_pkg::RES_OK;
              state_nxt  = bpa_pkg::S_DONE;
            end else begin
              cmd.set_init = 1'b1;
              cmd.set_val  = 1'b1;
              state_nxt    = bpa_pkg::S_SET;
            end
          end
          bpa_pkg::ACT_COLOR: begin
            cmd.rem_go  = 1'b1;
            cmd.rem_sel = bpa_pkg::SEL_COLOR;
            state_nxt   = bpa_pkg::S_REM_C;
          end
          default: state_nxt = bpa_pkg::S_IDLE;
        endcase
      end
      bpa_pkg::S_REM_S: begin
        if (sts.rem_done) begin
          cmd.alloc_init = 1'b1;
          state_nxt      = bpa_pkg::S_ASCAN;
        end
      end
      bpa_pkg::S_ASCAN: begin
        cmd.scan_a = 1'b1;
        if (sts.hit) begin
          state_nxt = sts.cnt_zero ? bpa_pkg::S_HIT : bpa_pkg::S_MARK;
        end else if (sts.fail) begin
          cmd.res_wr = 1'b1;
          cmd.res    = bpa_pkg::RES_FAIL;
          state_nxt  = bpa_pkg::S_DONE;
        end
      end
      bpa_pkg::S_MARK: begin
        cmd.set_init      = 1'b1;
        cmd.set_src_found = 1'b1;
        cmd.set_val       = 1'b1;
        state_nxt         = bpa_pkg::S_SET;
      end
      bpa_pkg::S_SET: begin
        cmd.set_step = 1'b1;
        if (sts.set_last) begin
          cmd.res_wr = 1'b1;
          cmd.res    = (sts.act == bpa_pkg::ACT_ALLOC) ? bpa_pkg::RES_HIT : bpa_pkg::RES_OK;
          state_nxt  = bpa_pkg::S_DONE;
        end
      end
      bpa_pkg::S_REM_C: begin
        if (sts.rem_done) begin
          cmd.col_save = 1'b1;
          cmd.rem_go   = 1'b1;
          cmd.rem_sel  = bpa_pkg::SEL_FIRST;
          state_nxt    = bpa_pkg::S_REM_F;
        end
      end
      bpa_pkg::S_REM_F: begin
        if (sts.rem_done) begin
          cmd.col_init = 1'b1;
          state_nxt    = bpa_pkg::S_CSCAN;
        end
      end
      bpa_pkg::S_CSCAN: begin
        cmd.scan_c = 1'b1;
        if (sts.hit) begin
          state_nxt = bpa_pkg::S_HIT;
        end else if (sts.fail) begin
          cmd.res_wr = 1'b1;
          cmd.res    = bpa_pkg::RES_FAIL;
          state_nxt  = bpa_pkg::S_DONE;
        end
      end
      bpa_pkg::S_HIT: begin
        cmd.res_wr = 1'b1;
        cmd.res    = bpa_pkg::RES_HIT;
        state_nxt  = bpa_pkg::S_DONE;
      end
      bpa_pkg::S_DONE: begin
        out_valid = 1'b1;
        state_nxt = bpa_pkg::S_IDLE;
      end
      default: state_nxt = bpa_pkg::S_IDLE;
    endcase
  end

endmodule

>>> sv/bpa_dp.sv
// datapath: used-page bitmap, config registers, scan counters and result registers
module bpa_dp #(
  parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bpa_pkg::cmd_t             cmd,
  output bpa_pkg::sts_t             sts,
  input  logic [1:0]                in_action,
  input  logic [bpa_pkg::PGW-1:0]   in_start_page,
  input  logic [bpa_pkg::CNTW-1:0]  in_page_count,
  input  logic [bpa_pkg::PGW-1:0]   in_color,
  output logic [1:0]                out_status,
  output logic [bpa_pkg::PGW-1:0]   out_page_index,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [bpa_pkg::CNTW-1:0]  cfg_data
);

  localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int NW = $clog2(MAX_PAGES + 1);
  localparam int PW = ((NW > bpa_pkg::CNTW) ? NW : bpa_pkg::CNTW) + 1;
  localparam logic [PW-1:0] MAXP = PW'(MAX_PAGES);

  logic used_mem [MAX_PAGES];

  logic [bpa_pkg::CNTW-1:0] region_pages_r;
  logic [bpa_pkg::PGW-1:0]  search_start_r;
  logic [bpa_pkg::CNTW-1:0] color_count_r;
  logic [bpa_pkg::PGW-1:0]  first_color_r;

  bpa_pkg::act_t            act_r;
  logic [bpa_pkg::PGW-1:0]  start_r;
  logic [bpa_pkg::CNTW-1:0] cnt_r;
  logic [bpa_pkg::PGW-1:0]  col_r;

  logic [PW-1:0] p_r;
  logic [PW-1:0] k_r;
  logic [PW-1:0] q_r;
  logic [PW-1:0] len_r;
  logic [PW-1:0] s_r;
  logic [PW-1:0] c_r;
  logic [PW-1:0] found_r;
  logic          ph_r;
  logic          val_r;
  logic          rd_vld_r;
  logic          rd_ph_r;
  logic [PW-1:0] rd_addr_r;
  logic          rd_q_r;
  logic [1:0]    stat_r;
  logic [bpa_pkg::PGW-1:0] page_r;

  logic [PW-1:0] n_w;
  logic [PW-1:0] rp_w;
  logic [PW-1:0] avail;
  logic [PW-1:0] need;
  logic [PW-1:0] cnt_w;
  logic          issue;
  logic          hit;
  logic          fail;
  logic [PW-1:0] hit_page;
  logic [PW-1:0] q_e;
  logic [PW-1:0] len_e;
  logic [PW-1:0] len_inc;
  logic [PW:0]   cx;
  logic [PW-1:0] cpage;
  logic          wr_en;

  logic [bpa_pkg::DIVW-1:0] rem_dvd;
  logic [PW-1:0]            rem_dvs;
  logic                     rem_done;
  logic [PW-1:0]            rem_val;

  assign rp_w  = PW'(region_pages_r);
  assign n_w   = (rp_w < MAXP) ? rp_w : MAXP;
  assign avail = (color_count_r == '0) ? PW'(1) : PW'(color_count_r);
  assign cnt_w = PW'(cnt_r);
  assign need  = (cnt_r == '0) ? PW'(1) : cnt_w;

  always_comb begin
    unique case (cmd.rem_sel)
      bpa_pkg::SEL_SEARCH: begin
        rem_dvd = search_start_r;
        rem_dvs = n_w;
      end
      bpa_pkg::SEL_COLOR: begin
        rem_dvd = col_r;
        rem_dvs = avail;
      end
      default: begin
        rem_dvd = first_color_r;
        rem_dvs = avail;
      end
    endcase
  end

  bpa_rem #(.DW(PW)) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.rem_go),
    .dividend (rem_dvd),
    .divisor  (rem_dvs),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // first colored candidate: (c + avail - f) folded once into [0, avail)
  always_comb begin
    cx    = {1'b0, c_r} + {1'b0, avail} - {1'b0, rem_val};
    cpage = (cx >= {1'b0, avail}) ? PW'(cx - {1'b0, avail}) : PW'(cx);
  end

  assign issue = (cmd.scan_a || cmd.scan_c) && (p_r < n_w);

  // evaluate the bit read in the previous cycle
  always_comb begin
    hit      = 1'b0;
    fail     = 1'b0;
    q_e      = q_r;
    len_e    = len_r;
    len_inc  = len_r + 1'b1;
    hit_page = q_r;
    if (cmd.scan_a) begin
      if (rd_vld_r) begin
        if (!rd_ph_r) begin
          if (!rd_q_r) begin
            if (len_r == '0) q_e = rd_addr_r;
            len_e = len_inc;
            if (len_inc >= need) hit = 1'b1;
          end else begin
            len_e = '0;
          end
          // runs never wrap past the region end
          if (rd_addr_r == n_w - 1'b1) len_e = '0;
        end else begin
          if (!rd_q_r) begin
            if (len_r == '0 && rd_addr_r >= s_r) begin
              fail = 1'b1;
            end else begin
              if (len_r == '0) q_e = rd_addr_r;
              len_e = len_inc;
              if (len_inc >= need) hit = 1'b1;
            end
          end else begin
            if (rd_addr_r >= s_r) fail = 1'b1;
            len_e = '0;
          end
          if (rd_addr_r == n_w - 1'b1 && !hit) fail = 1'b1;
        end
        hit_page = q_e;
      end
    end else if (cmd.scan_c) begin
      hit      = rd_vld_r && !rd_q_r;
      fail     = !rd_vld_r && !issue;
      hit_page = rd_addr_r;
    end
  end

  assign wr_en = cmd.clr || cmd.set_step;

  always_ff @(posedge clk) begin
    if (wr_en) used_mem[p_r[AW-1:0]] <= cmd.clr ? 1'b0 : val_r;
    if (issue) rd_q_r <= used_mem[p_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_pages_r <= bpa_pkg::CNTW'(4096);
      search_start_r <= '0;
      color_count_r  <= bpa_pkg::CNTW'(256);
      first_color_r  <= '0;
      p_r            <= '0;
      rd_vld_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (bpa_pkg::cfg_idx_t'(cfg_index))
          bpa_pkg::CFG_REGION: region_pages_r <= cfg_data;
          bpa_pkg::CFG_SEARCH: search_start_r <= cfg_data[bpa_pkg::PGW-1:0];
          bpa_pkg::CFG_COLORS: color_count_r  <= cfg_data;
          bpa_pkg::CFG_FIRST:  first_color_r  <= cfg_data[bpa_pkg::PGW-1:0];
          default: ;
        endcase
      end
      rd_vld_r <= issue;
      if (cmd.clr) begin
        p_r <= p_r + 1'b1;
      end else if (cmd.alloc_init) begin
        p_r <= rem_val;
      end else if (cmd.col_init) begin
        p_r <= cpage;
      end else if (cmd.set_init) begin
        p_r <= cmd.set_src_found ? found_r : PW'(start_r);
      end else if (cmd.set_step) begin
        p_r <= p_r + 1'b1;
      end else if (issue) begin
        if (cmd.scan_c) begin
          p_r <= p_r + avail;
        end else if (!ph_r && p_r == n_w - 1'b1) begin
          p_r <= '0;
        end else begin
          p_r <= p_r + 1'b1;
        end
      end
      if (cmd.load) p_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= bpa_pkg::act_t'(in_action);
      start_r <= in_start_page;
      cnt_r   <= in_page_count;
      col_r   <= in_color;
    end
    if (cmd.alloc_init) begin
      s_r   <= rem_val;
      ph_r  <= 1'b0;
      len_r <= '0;
      q_r   <= '0;
    end else if (cmd.scan_a) begin
      q_r   <= q_e;
      len_r <= len_e;
      if (issue && p_r == n_w - 1'b1) ph_r <= 1'b1;
    end
    if (issue) begin
      rd_addr_r <= p_r;
      rd_ph_r   <= ph_r;
    end
    if (cmd.col_save) c_r <= rem_val;
    if (hit) found_r <= hit_page;
    if (cmd.set_init) begin
      k_r   <= '0;
      val_r <= cmd.set_val;
    end else if (cmd.set_step) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.res_wr) begin
      unique case (cmd.res)
        bpa_pkg::RES_OK: begin
          stat_r <= bpa_pkg::STAT_OK;
          page_r <= '0;
        end
        bpa_pkg::RES_FAIL: begin
          stat_r <= bpa_pkg::STAT_NOSPACE;
          page_r <= '0;
        end
        bpa_pkg::RES_INVAL: begin
          stat_r <= bpa_pkg::STAT_INVAL;
          page_r <= '0;
        end
        bpa_pkg::RES_HIT: begin
          stat_r <= bpa_pkg::STAT_OK;
          page_r <= found_r[bpa_pkg::PGW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.clr_last  = (p_r == MAXP - 1'b1);
    sts.act       = act_r;
    sts.n_zero    = (n_w == '0);
    sts.start_out = (PW'(start_r) >= n_w);
    sts.cnt_zero  = (cnt_r == '0);
    sts.rem_done  = rem_done;
    sts.hit       = hit;
    sts.fail      = fail;
    sts.set_last  = (p_r + 1'b1 >= n_w) || (k_r + 1'b1 >= cnt_w);
  end

  assign cfg_ready      = 1'b1;
  assign out_status     = stat_r;
  assign out_page_index = page_r;

endmodule

>>> sv/bitmap_page_allocator.sv
// top level of the bitmap page allocator
//
// Command channel: present in_action, in_start_page, in_page_count and in_color
// with start high; the word is taken at a clock edge where busy is low. busy then
// stays high until the result has been shown. Exactly one result word follows each
// command: out_status and out_page_index hold for one cycle with out_valid high.
// The receiver cannot stall; the word is gone after that cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, ready always high;
// write only while busy is low.
// The bitmap is a single-port memory read or written one page per cycle, so timing
// follows the bits touched: alloc computes the start modulo, scans pages and then
// marks page_count pages; colored computes two remainders and visits candidate
// pages; free/reserve writes the pages.
// Reset: synchronous, active low. Afterwards a clearing pass writes every bitmap
// entry to free with busy high; config writes are taken meanwhile.
module bitmap_page_allocator #(
  parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_action,
  input  logic [bpa_pkg::PGW-1:0]   in_start_page,
  input  logic [bpa_pkg::CNTW-1:0]  in_page_count,
  input  logic [bpa_pkg::PGW-1:0]   in_color,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [bpa_pkg::PGW-1:0]   out_page_index,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [bpa_pkg::CNTW-1:0]  cfg_data
);

  bpa_pkg::cmd_t cmd;
  bpa_pkg::sts_t sts;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpa_dp #(.MAX_PAGES(MAX_PAGES)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (in_action),
    .in_start_page  (in_start_page),
    .in_page_count  (in_page_count),
    .in_color       (in_color),
    .out_status     (out_status),
    .out_page_index (out_page_index),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

endmodule

>>> sv/bpa_chk.sv
// port-level checker for the bitmap page allocator, bound to the top level
module bpa_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic [1:0]                in_action,
  input logic [bpa_pkg::PGW-1:0]   in_start_page,
  input logic [bpa_pkg::CNTW-1:0]  in_page_count,
  input logic [bpa_pkg::PGW-1:0]   in_color,
  input logic                      out_valid,
  input logic [1:0]                out_status,
  input logic [bpa_pkg::PGW-1:0]   out_page_index,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [1:0]                cfg_index,
  input logic [bpa_pkg::CNTW-1:0]  cfg_data
);

  // clearing pass keeps commands out right after reset
  a_clear_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted word did not make block busy");

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy && out_status <= bpa_pkg::STAT_INVAL))
    else $error("bad result status");

  a_err_page: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bpa_pkg::STAT_OK) |-> (out_page_index == '0))
    else $error("page index not zero on error");

endmodule

bind bitmap_page_allocator bpa_chk u_chk (.*);
